// ===== hdl/adp_pkg.sv =====
// Shared types, codes and helpers for the data-processing ALU block.
// No dependencies; every other file in hdl/ uses this package by scoped name.
`default_nettype none

package adp_pkg;

   // Default depth of the queue between decode and execute
   localparam int ADP_QUEUE_DEPTH = 2;

   // Condition codes
   localparam logic [3:0] COND_EQ = 4'd0;
   localparam logic [3:0] COND_NE = 4'd1;
   localparam logic [3:0] COND_CS = 4'd2;
   localparam logic [3:0] COND_CC = 4'd3;
   localparam logic [3:0] COND_MI = 4'd4;
   localparam logic [3:0] COND_PL = 4'd5;
   localparam logic [3:0] COND_VS = 4'd6;
   localparam logic [3:0] COND_VC = 4'd7;
   localparam logic [3:0] COND_HI = 4'd8;
   localparam logic [3:0] COND_LS = 4'd9;
   localparam logic [3:0] COND_GE = 4'd10;
   localparam logic [3:0] COND_LT = 4'd11;
   localparam logic [3:0] COND_GT = 4'd12;
   localparam logic [3:0] COND_LE = 4'd13;
   localparam logic [3:0] COND_AL = 4'd14;
   localparam logic [3:0] COND_NV = 4'd15;

   // ALU operation codes
   localparam logic [3:0] OP_AND = 4'd0;
   localparam logic [3:0] OP_EOR = 4'd1;
   localparam logic [3:0] OP_SUB = 4'd2;
   localparam logic [3:0] OP_RSB = 4'd3;
   localparam logic [3:0] OP_ADD = 4'd4;
   localparam logic [3:0] OP_ADC = 4'd5;
   localparam logic [3:0] OP_SBC = 4'd6;
   localparam logic [3:0] OP_RSC = 4'd7;
   localparam logic [3:0] OP_TST = 4'd8;
   localparam logic [3:0] OP_TEQ = 4'd9;
   localparam logic [3:0] OP_CMP = 4'd10;
   localparam logic [3:0] OP_CMN = 4'd11;
   localparam logic [3:0] OP_ORR = 4'd12;
   localparam logic [3:0] OP_MOV = 4'd13;
   localparam logic [3:0] OP_BIC = 4'd14;
   localparam logic [3:0] OP_MVN = 4'd15;

   // Shift types
   localparam logic [1:0] SHIFT_LSL = 2'd0;
   localparam logic [1:0] SHIFT_LSR = 2'd1;
   localparam logic [1:0] SHIFT_ASR = 2'd2;
   localparam logic [1:0] SHIFT_ROR = 2'd3;

   // Adder carry-in select
   localparam logic [1:0] CIN_ZERO = 2'd0;
   localparam logic [1:0] CIN_ONE  = 2'd1;
   localparam logic [1:0] CIN_FLAG = 2'd2;

   // Request payload
   typedef struct packed {
      logic [3:0]  condition;
      logic [3:0]  opcode;
      logic        immediate_form;
      logic        set_flags;
      logic [31:0] first_value;
      logic [31:0] shifted_reg_value;
      logic [7:0]  shift_reg_byte;
      logic [11:0] operand_field;
   } adp_req_type;

   // Response payload
   typedef struct packed {
      logic [31:0] result_value;
      logic        write_dest;
      logic        condition_passed;
      logic        flag_n;
      logic        flag_z;
      logic        flag_c;
      logic        flag_v;
   } adp_rsp_type;

   // Decoded request held in the queue between decode and execute
   typedef struct packed {
      logic [3:0]  condition;
      logic [3:0]  opcode;
      logic        set_flags;
      logic [31:0] first_value;
      logic [31:0] operand2;     // shifter output, bit 31 open when rrx is set
      logic        shift_carry;  // shifter carry when not taken from C
      logic        carry_old;    // shifter carry is the current C flag
      logic        rrx;          // operand2 bit 31 is the current C flag
      logic        arith;        // adder result, C and V from the adder
      logic        write_dest;
      logic        add_swap;     // reverse subtract: operand2 on the left
      logic        add_invert;   // invert the right adder input
      logic [1:0]  cin_sel;
   } adp_entry_type;

   // Evaluate a condition code against NZCV (N bit 3, Z bit 2, C bit 1, V bit 0)
   function automatic logic cond_holds(input logic [3:0] cc, input logic [3:0] f);
      logic n, z, c, v, ok;
      n = f[3];
      z = f[2];
      c = f[1];
      v = f[0];
      unique case (cc)
         COND_EQ: ok = z;
         COND_NE: ok = !z;
         COND_CS: ok = c;
         COND_CC: ok = !c;
         COND_MI: ok = n;
         COND_PL: ok = !n;
         COND_VS: ok = v;
         COND_VC: ok = !v;
         COND_HI: ok = c && !z;
         COND_LS: ok = !c || z;
         COND_GE: ok = (n == v);
         COND_LT: ok = (n != v);
         COND_GT: ok = !z && (n == v);
         COND_LE: ok = z || (n != v);
         COND_AL: ok = 1'b1;
         default: ok = 1'b0;
      endcase
      return ok;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/adp_front.sv =====
// Decode stage: barrel shifter and operation classification for one request.
// Depends on adp_pkg for the payload and entry types and the code constants.
`default_nettype none

module adp_front (
   input  wire adp_pkg::adp_req_type   req,
   output adp_pkg::adp_entry_type      entry
);

   // Rotate right by a 5-bit amount
   function automatic logic [31:0] ror32(input logic [31:0] x, input logic [4:0] r);
      logic [5:0] r6;
      r6 = {1'b0, r};
      return (x >> r6) | (x << (6'd32 - r6));
   endfunction

   logic [31:0]        rm;
   logic [1:0]         sh_type;
   logic               reg_amount;
   logic [7:0]         amt8;
   logic [5:0]         k6;
   logic [32:0]        left33;
   logic [32:0]        right33;
   logic signed [32:0] asr33;
   logic [31:0]        rot_val;
   logic [31:0]        imm_val;
   logic [31:0]        op2;
   logic               sh_c;
   logic               c_old;
   logic               rrx;

   assign rm         = req.shifted_reg_value;
   assign sh_type    = req.operand_field[6:5];
   assign reg_amount = req.operand_field[4];
   assign amt8       = reg_amount ? req.shift_reg_byte : {3'b000, req.operand_field[11:7]};
   assign imm_val    = ror32({24'd0, req.operand_field[7:0]},
                             {req.operand_field[11:8], 1'b0});

   // Clamp large amounts; immediate LSR and ASR by zero mean a shift by 32
   always_comb begin
      if (amt8 > 8'd32) begin
         k6 = 6'd33;
      end else begin
         k6 = amt8[5:0];
      end
      if (!reg_amount && (amt8 == 8'd0) &&
          ((sh_type == adp_pkg::SHIFT_LSR) || (sh_type == adp_pkg::SHIFT_ASR))) begin
         k6 = 6'd32;
      end
   end

   // Shift with the carry bit carried alongside
   assign left33  = {1'b0, rm} << k6;
   assign right33 = {rm, 1'b0} >> k6;
   assign asr33   = $signed({rm, 1'b0}) >>> k6;
   assign rot_val = ror32(rm, amt8[4:0]);

   // Select operand 2 and its carry
   always_comb begin
      op2   = rm;
      sh_c  = 1'b0;
      c_old = 1'b0;
      rrx   = 1'b0;
      if (req.immediate_form) begin
         op2 = imm_val;
         if (req.operand_field[11:8] == 4'd0) begin
            c_old = 1'b1;
         end else begin
            sh_c = imm_val[31];
         end
      end else if (reg_amount && (amt8 == 8'd0)) begin
         c_old = 1'b1;
      end else begin
         case (sh_type)
            adp_pkg::SHIFT_LSL: begin
               if (amt8 == 8'd0) begin
                  c_old = 1'b1;
               end else begin
                  op2  = left33[31:0];
                  sh_c = left33[32];
               end
            end
            adp_pkg::SHIFT_LSR: begin
               op2  = right33[32:1];
               sh_c = right33[0];
            end
            adp_pkg::SHIFT_ASR: begin
               op2  = asr33[32:1];
               sh_c = asr33[0];
            end
            default: begin
               if (amt8[4:0] != 5'd0) begin
                  op2  = rot_val;
                  sh_c = rot_val[31];
               end else if (reg_amount) begin
                  // rotate by a multiple of 32: value unchanged
                  sh_c = rm[31];
               end else begin
                  // rotate right extended through C
                  op2  = {1'b0, rm[31:1]};
                  sh_c = rm[0];
                  rrx  = 1'b1;
               end
            end
         endcase
      end
   end

   // Classify the ALU operation
   always_comb begin
      entry.condition   = req.condition;
      entry.opcode      = req.opcode;
      entry.set_flags   = req.set_flags;
      entry.first_value = req.first_value;
      entry.operand2    = op2;
      entry.shift_carry = sh_c;
      entry.carry_old   = c_old;
      entry.rrx         = rrx;
      entry.arith       = 1'b1;
      entry.add_swap    = 1'b0;
      entry.add_invert  = 1'b0;
      entry.cin_sel     = adp_pkg::CIN_ZERO;
      unique case (req.opcode) inside
         adp_pkg::OP_SUB, adp_pkg::OP_CMP: begin
            entry.add_invert = 1'b1;
            entry.cin_sel    = adp_pkg::CIN_ONE;
         end
         adp_pkg::OP_RSB: begin
            entry.add_swap   = 1'b1;
            entry.add_invert = 1'b1;
            entry.cin_sel    = adp_pkg::CIN_ONE;
         end
         adp_pkg::OP_ADD, adp_pkg::OP_CMN: begin
            entry.cin_sel = adp_pkg::CIN_ZERO;
         end
         adp_pkg::OP_ADC: begin
            entry.cin_sel = adp_pkg::CIN_FLAG;
         end
         adp_pkg::OP_SBC: begin
            entry.add_invert = 1'b1;
            entry.cin_sel    = adp_pkg::CIN_FLAG;
         end
         adp_pkg::OP_RSC: begin
            entry.add_swap   = 1'b1;
            entry.add_invert = 1'b1;
            entry.cin_sel    = adp_pkg::CIN_FLAG;
         end
         default: begin
            entry.arith = 1'b0;
         end
      endcase
      unique case (req.opcode) inside
         adp_pkg::OP_TST, adp_pkg::OP_TEQ, adp_pkg::OP_CMP, adp_pkg::OP_CMN: begin
            entry.write_dest = 1'b0;
         end
         default: begin
            entry.write_dest = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/adp_queue.sv =====
// Short queue of decoded requests between the decode and execute stages.
// Depends on adp_pkg for the entry type.
`default_nettype none

module adp_queue #(
   parameter int DEPTH = adp_pkg::ADP_QUEUE_DEPTH
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          in_valid,
   output logic                         in_stall,
   input  wire adp_pkg::adp_entry_type  in_entry,
   output logic                         out_valid,
   input  wire                          out_pop,
   output adp_pkg::adp_entry_type       out_entry
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   adp_pkg::adp_entry_type slot_ff [DEPTH];
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign in_stall  = (count_ff == CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && !in_stall;
   assign pop       = out_pop && out_valid;
   assign out_entry = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed entries
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue occupancy above depth");

   a_empty_passthrough: assert property (@(posedge clock) disable iff (reset)
      (push && (count_ff == '0)) |=> (out_valid && (out_entry == $past(in_entry))))
      else $error("entry pushed into empty queue not at head");

endmodule

`default_nettype wire

// ===== hdl/adp_back.sv =====
// Execute stage: condition test, ALU, flag update and response register.
// Depends on adp_pkg for the entry and response types and the code constants.
`default_nettype none

module adp_back (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          q_valid,
   output logic                         q_pop,
   input  wire adp_pkg::adp_entry_type  q_entry,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output adp_pkg::adp_rsp_type         rsp_data
);

   logic [3:0]           flags_ff, flags_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   adp_pkg::adp_rsp_type rsp_ff, rsp_in;

   logic        c_old;
   logic        pass;
   logic [31:0] op_b;
   logic        sh_c;
   logic [31:0] add_x;
   logic [31:0] add_y;
   logic        cin;
   logic [32:0] sum;
   logic        add_v;
   logic [31:0] res;
   logic [3:0]  new_flags;

   assign c_old = flags_ff[1];
   assign pass  = adp_pkg::cond_holds(q_entry.condition, flags_ff);
   assign q_pop = q_valid && (!rsp_valid_ff || !rsp_stall);

   // Finish operand 2 with the current carry
   assign op_b = q_entry.rrx ? {c_old, q_entry.operand2[30:0]} : q_entry.operand2;
   assign sh_c = q_entry.carry_old ? c_old : q_entry.shift_carry;

   // Adder with operand swap and inversion for the subtract forms
   always_comb begin
      add_x = q_entry.add_swap ? op_b : q_entry.first_value;
      add_y = q_entry.add_swap ? q_entry.first_value : op_b;
      if (q_entry.add_invert) begin
         add_y = ~add_y;
      end
      case (q_entry.cin_sel)
         adp_pkg::CIN_ONE:  cin = 1'b1;
         adp_pkg::CIN_FLAG: cin = c_old;
         default:           cin = 1'b0;
      endcase
   end

   assign sum   = {1'b0, add_x} + {1'b0, add_y} + {32'd0, cin};
   assign add_v = ~(add_x[31] ^ add_y[31]) & (add_x[31] ^ sum[31]);

   // Select the result
   always_comb begin
      case (q_entry.opcode) inside
         adp_pkg::OP_AND, adp_pkg::OP_TST: res = q_entry.first_value & op_b;
         adp_pkg::OP_EOR, adp_pkg::OP_TEQ: res = q_entry.first_value ^ op_b;
         adp_pkg::OP_ORR:                  res = q_entry.first_value | op_b;
         adp_pkg::OP_MOV:                  res = op_b;
         adp_pkg::OP_BIC:                  res = q_entry.first_value & ~op_b;
         adp_pkg::OP_MVN:                  res = ~op_b;
         default:                          res = sum[31:0];
      endcase
   end

   // Compute the flags after this request
   always_comb begin
      new_flags = flags_ff;
      if (pass && q_entry.set_flags) begin
         new_flags[3] = res[31];
         new_flags[2] = (res == 32'd0);
         if (q_entry.arith) begin
            new_flags[1] = sum[32];
            new_flags[0] = add_v;
         end else begin
            new_flags[1] = sh_c;
         end
      end
   end

   // Build the response and hold it while stalled
   always_comb begin
      flags_in     = q_pop ? new_flags : flags_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (q_pop) begin
         rsp_valid_in            = 1'b1;
         rsp_in.result_value     = pass ? res : 32'd0;
         rsp_in.write_dest       = pass && q_entry.write_dest;
         rsp_in.condition_passed = pass;
         rsp_in.flag_n           = new_flags[3];
         rsp_in.flag_z           = new_flags[2];
         rsp_in.flag_c           = new_flags[1];
         rsp_in.flag_v           = new_flags[0];
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff     <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         flags_ff     <= flags_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_flags_only_on_exec: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (flags_ff != $past(flags_ff)))
         |-> $past(q_pop && pass && q_entry.set_flags))
      else $error("flags changed without an executed flag-setting request");

   a_rsp_from_pop: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> $past(q_pop))
      else $error("response appeared without a popped request");

   a_failed_no_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.condition_passed)
         |-> (!rsp_ff.write_dest && (rsp_ff.result_value == 32'd0)))
      else $error("failed condition produced a write");

   a_flags_match_rsp: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (flags_ff == {rsp_ff.flag_n, rsp_ff.flag_z, rsp_ff.flag_c, rsp_ff.flag_v}))
      else $error("stored flags differ from reported flags");

endmodule

`default_nettype wire

// ===== hdl/arm_data_processing_alu.sv =====
// Top level of the data-processing ALU: decode, request queue and execute.
// Depends on adp_pkg, adp_front, adp_queue and adp_back.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------
//   req     | in        | req_valid/req_stall | adp_pkg::adp_req_type
//   rsp     | out       | rsp_valid/rsp_stall | adp_pkg::adp_rsp_type
//
// One request per cycle sustained while rsp_stall is low; a request's response passes
// through its queue slot at acceptance and then into the response register.
// The NZCV register in the execute stage feeds the next request directly,
// which sets the one-per-cycle figure.
// Synchronous active-high reset clears flags, queue and response valid.
// A stalled response lets the queue fill; req_stall rises when it is full.
`default_nettype none

module arm_data_processing_alu #(
   parameter int QUEUE_DEPTH = adp_pkg::ADP_QUEUE_DEPTH
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_stall,
   input  wire adp_pkg::adp_req_type  req_data,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output adp_pkg::adp_rsp_type       rsp_data
);

   adp_pkg::adp_entry_type dec_entry;
   adp_pkg::adp_entry_type head_entry;
   logic                   head_valid;
   logic                   head_pop;

   // Decode and shift
   adp_front u_front (
      .req   (req_data),
      .entry (dec_entry)
   );

   // Queue decoded requests
   adp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_entry  (dec_entry),
      .out_valid (head_valid),
      .out_pop   (head_pop),
      .out_entry (head_entry)
   );

   // Execute and respond
   adp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (head_valid),
      .q_pop     (head_pop),
      .q_entry   (head_entry),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking bench for arm_data_processing_alu: directed and random requests, with
// results predicted by an in-bench flag-tracking ALU model, under varied idling and stalls.
// Depends on adp_pkg and the block's RTL in hdl/.
`timescale 1ns / 100ps

module tb_top;

   localparam int HOLD_CYCLES  = 400;
   localparam int STUCK_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_ITEMS  = 375;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   adp_pkg::adp_req_type req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   adp_pkg::adp_rsp_type rsp_data;

   // model state and scoreboard
   logic [3:0]           tracked_nzcv = 4'b0000;
   adp_pkg::adp_rsp_type pending_responses[$];
   int                   mismatch_count = 0;
   int                   stuck_cycles = 0;

   // idling controls
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          hold_token = 0;
   int          hold_taken = 0;
   int          hold_left = 0;

   arm_data_processing_alu dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] rotate_right(input logic [31:0] v, input logic [4:0] n);
      logic [63:0] d;
      d = {v, v} >> n;
      return d[31:0];
   endfunction

   // return {carry, overflow, sum} of a + b + cin
   function automatic logic [33:0] add_flags(input logic [31:0] a, input logic [31:0] b,
                                             input logic cin);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b} + {32'b0, cin};
      return {s[32], ~(a[31] ^ b[31]) & (a[31] ^ s[31]), s[31:0]};
   endfunction

   // Predict the response to one request and advance the tracked flags.
   function automatic adp_pkg::adp_rsp_type compute_alu_response(
      input adp_pkg::adp_req_type r);
      logic                 n, z, c, v, passed, shift_c, add_c, add_v, arith, writes;
      logic [31:0]          rm, rn, op2, res;
      logic [7:0]           amt;
      logic [1:0]           kind;
      logic [63:0]          wide;
      logic signed [63:0]   swide;
      adp_pkg::adp_rsp_type rsp;
      {n, z, c, v} = tracked_nzcv;
      rsp = '0;
      // evaluate the condition against the current flags
      case (r.condition)
         adp_pkg::COND_EQ: passed = z;
         adp_pkg::COND_NE: passed = !z;
         adp_pkg::COND_CS: passed = c;
         adp_pkg::COND_CC: passed = !c;
         adp_pkg::COND_MI: passed = n;
         adp_pkg::COND_PL: passed = !n;
         adp_pkg::COND_VS: passed = v;
         adp_pkg::COND_VC: passed = !v;
         adp_pkg::COND_HI: passed = c && !z;
         adp_pkg::COND_LS: passed = !c || z;
         adp_pkg::COND_GE: passed = (n == v);
         adp_pkg::COND_LT: passed = (n != v);
         adp_pkg::COND_GT: passed = !z && (n == v);
         adp_pkg::COND_LE: passed = z || (n != v);
         adp_pkg::COND_AL: passed = 1'b1;
         default:          passed = 1'b0;
      endcase
      if (passed) begin
         rn = r.first_value;
         rm = r.shifted_reg_value;
         kind = r.operand_field[6:5];
         shift_c = c;
         // form the second operand and the shifter carry
         if (r.immediate_form) begin
            amt = {3'b000, r.operand_field[11:8], 1'b0};
            op2 = rotate_right({24'b0, r.operand_field[7:0]}, amt[4:0]);
            if (amt != 8'd0) shift_c = op2[31];
         end else begin
            if (r.operand_field[4]) begin
               amt = r.shift_reg_byte;
            end else begin
               amt = {3'b000, r.operand_field[11:7]};
               // an immediate amount of zero means a shift by 32 for LSR and ASR
               if (amt == 8'd0 && (kind == adp_pkg::SHIFT_LSR || kind == adp_pkg::SHIFT_ASR))
                  amt = 8'd32;
            end
            if (amt == 8'd0 && kind == adp_pkg::SHIFT_ROR && !r.operand_field[4]) begin
               // rotate right extended through the carry
               op2 = {c, rm[31:1]};
               shift_c = rm[0];
            end else if (amt == 8'd0) begin
               op2 = rm;
            end else begin
               case (kind)
                  adp_pkg::SHIFT_LSL: begin
                     wide = {32'b0, rm} << amt;
                     op2 = wide[31:0];
                     shift_c = wide[32];
                  end
                  adp_pkg::SHIFT_LSR: begin
                     wide = {rm, 32'b0} >> amt;
                     op2 = wide[63:32];
                     shift_c = wide[31];
                  end
                  adp_pkg::SHIFT_ASR: begin
                     swide = $signed({rm, 32'b0}) >>> amt;
                     op2 = swide[63:32];
                     shift_c = swide[31];
                  end
                  default: begin
                     op2 = rotate_right(rm, amt[4:0]);
                     shift_c = op2[31];
                  end
               endcase
            end
         end
         // apply the ALU operation
         arith = 1'b1;
         writes = 1'b1;
         add_c = 1'b0;
         add_v = 1'b0;
         case (r.opcode)
            adp_pkg::OP_AND: begin res = rn & op2; arith = 1'b0; end
            adp_pkg::OP_EOR: begin res = rn ^ op2; arith = 1'b0; end
            adp_pkg::OP_SUB: {add_c, add_v, res} = add_flags(rn, ~op2, 1'b1);
            adp_pkg::OP_RSB: {add_c, add_v, res} = add_flags(op2, ~rn, 1'b1);
            adp_pkg::OP_ADD: {add_c, add_v, res} = add_flags(rn, op2, 1'b0);
            adp_pkg::OP_ADC: {add_c, add_v, res} = add_flags(rn, op2, c);
            adp_pkg::OP_SBC: {add_c, add_v, res} = add_flags(rn, ~op2, c);
            adp_pkg::OP_RSC: {add_c, add_v, res} = add_flags(op2, ~rn, c);
            adp_pkg::OP_TST: begin res = rn & op2; arith = 1'b0; writes = 1'b0; end
            adp_pkg::OP_TEQ: begin res = rn ^ op2; arith = 1'b0; writes = 1'b0; end
            adp_pkg::OP_CMP: begin
               {add_c, add_v, res} = add_flags(rn, ~op2, 1'b1);
               writes = 1'b0;
            end
            adp_pkg::OP_CMN: begin
               {add_c, add_v, res} = add_flags(rn, op2, 1'b0);
               writes = 1'b0;
            end
            adp_pkg::OP_ORR: begin res = rn | op2; arith = 1'b0; end
            adp_pkg::OP_MOV: begin res = op2; arith = 1'b0; end
            adp_pkg::OP_BIC: begin res = rn & ~op2; arith = 1'b0; end
            default: begin res = ~op2; arith = 1'b0; end
         endcase
         // update flags only when the S bit is set
         if (r.set_flags) begin
            n = res[31];
            z = (res == 32'd0);
            if (arith) begin
               c = add_c;
               v = add_v;
            end else begin
               c = shift_c;
            end
            tracked_nzcv = {n, z, c, v};
         end
         rsp.result_value = res;
         rsp.write_dest = writes;
         rsp.condition_passed = 1'b1;
      end
      rsp.flag_n = n;
      rsp.flag_z = z;
      rsp.flag_c = c;
      rsp.flag_v = v;
      return rsp;
   endfunction

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, name, want, got);
      end
   endtask

   // Predict on each accepted request, check each accepted response, track progress.
   always @(posedge clock) begin
      if (reset) begin
         tracked_nzcv = 4'b0000;
         stuck_cycles <= 0;
      end else begin
         if (req_valid && !req_stall)
            pending_responses.push_back(compute_alu_response(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (pending_responses.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: response with no request outstanding", $realtime);
            end else begin
               check_field("result_value", rsp_data.result_value,
                           pending_responses[0].result_value);
               check_field("write_dest", 32'(rsp_data.write_dest),
                           32'(pending_responses[0].write_dest));
               check_field("condition_passed", 32'(rsp_data.condition_passed),
                           32'(pending_responses[0].condition_passed));
               check_field("flag_n", 32'(rsp_data.flag_n), 32'(pending_responses[0].flag_n));
               check_field("flag_z", 32'(rsp_data.flag_z), 32'(pending_responses[0].flag_z));
               check_field("flag_c", 32'(rsp_data.flag_c), 32'(pending_responses[0].flag_c));
               check_field("flag_v", 32'(rsp_data.flag_v), 32'(pending_responses[0].flag_v));
               void'(pending_responses.pop_front());
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            stuck_cycles <= 0;
         else
            stuck_cycles <= stuck_cycles + 1;
      end
   end

   // Drive the response stall: a requested long hold, else random stalls.
   always @(posedge clock) begin
      if (hold_token != hold_taken) begin
         hold_taken <= hold_token;
         hold_left <= HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Abort when nothing moves for too long.
   initial begin
      wait (stuck_cycles >= STUCK_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   function automatic adp_pkg::adp_req_type make_request(
      input logic [3:0] cond, input logic [3:0] op, input logic imm, input logic s,
      input logic [31:0] rn, input logic [31:0] rm, input logic [7:0] rs,
      input logic [11:0] field);
      adp_pkg::adp_req_type r;
      r.condition = cond;
      r.opcode = op;
      r.immediate_form = imm;
      r.set_flags = s;
      r.first_value = rn;
      r.shifted_reg_value = rm;
      r.shift_reg_byte = rs;
      r.operand_field = field;
      return r;
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         4: return 32'h0000_0001;
         default: return $urandom();
      endcase
   endfunction

   function automatic adp_pkg::adp_req_type random_request();
      adp_pkg::adp_req_type r;
      // keep most requests unconditional so the flags keep moving
      r.condition = ($urandom_range(2) == 0) ? 4'($urandom_range(15)) : adp_pkg::COND_AL;
      r.opcode = 4'($urandom_range(15));
      r.immediate_form = 1'($urandom_range(1));
      r.set_flags = ($urandom_range(3) != 0);
      r.first_value = pick_word();
      r.shifted_reg_value = pick_word();
      case ($urandom_range(7))
         0: r.shift_reg_byte = 8'd0;
         1: r.shift_reg_byte = 8'd32;
         2: r.shift_reg_byte = 8'($urandom_range(255, 33));
         3: r.shift_reg_byte = {3'($urandom_range(7, 1)), 5'd0};
         default: r.shift_reg_byte = 8'($urandom_range(31, 1));
      endcase
      r.operand_field = 12'($urandom_range(4095));
      // zero immediate shift amounts select the odd encodings, so make them common
      if ($urandom_range(3) == 0) r.operand_field[11:7] = 5'd0;
      return r;
   endfunction

   // Offer one request after random idle cycles and hold it until accepted.
   task automatic send_request(input adp_pkg::adp_req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      send_idle_pct = sender_pct;
      stall_pct <= receiver_pct;
   endtask

   task automatic run_random_requests(input int count);
      repeat (count) send_request(random_request());
   endtask

   task automatic test_directed_cases();
      set_idling(0, 0);
      // immediate operands: rotate zero keeps the old carry, full rotate and field
      send_request(make_request(adp_pkg::COND_AL, adp_pkg::OP_MOV, 1'b1, 1'b1,
                                32'h0, 32'h0, 8'h00, 12'h000));
      send_request(make_request(adp_pkg::COND_AL, adp_pkg::OP_MVN, 1'b1, 1'b1,
                                32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 12'hFFF));
      // adder carry out, then overflow on a conditional add with carry
      send_request(make_request(adp_pkg::COND_AL, adp_pkg::OP_ADD, 1'b0, 1'b1,
                                32'hFFFF_FFFF, 32'h1, 8'h00, 12'h000));
      send_request(make_request(adp_pkg::COND_EQ, adp_pkg::OP_ADC, 1'b0, 1'b1,
                                32'h7FFF_FFFF, 32'h0, 8'h00, 12'h000));
      // immediate LSR and ASR by zero act as 32, immediate ROR by zero is RRX
      send_request(make_request(adp_pkg::COND_AL, adp_pkg::OP_SUB, 1'b0, 1'b1,
                                32'h0, 32'hFFFF_FFFF, 8'h00, 12'h020));
      send_request(make_request(adp_pkg::COND_AL, adp_pkg::OP_RSB, 1'b0, 1'b1,
                                32'h1, 32'h8000_0000, 8'h00, 12'h040));
      send_request(make_request(adp_pkg::COND_AL, adp_pkg::OP_SBC, 1'b0, 1'b1,
                                32'h5, 32'h1, 8'h00, 12'h060));
      // register shifts by 32 and beyond
      send_request(make_request(adp_pkg::COND_AL, adp_pkg::OP_RSC, 1'b0, 1'b1,
                                32'h0, 32'h3, 8'd32, 12'h010));
      send_request(make_request(adp_pkg::COND_AL, adp_pkg::OP_AND, 1'b0, 1'b1,
                                32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd33, 12'h010));
      send_request(make_request(adp_pkg::COND_AL, adp_pkg::OP_EOR, 1'b0, 1'b1,
                                32'h0, 32'h8000_0001, 8'd32, 12'h030));
      send_request(make_request(adp_pkg::COND_AL, adp_pkg::OP_ORR, 1'b0, 1'b1,
                                32'h0, 32'hFFFF_FFFF, 8'd200, 12'h030));
      send_request(make_request(adp_pkg::COND_AL, adp_pkg::OP_BIC, 1'b0, 1'b1,
                                32'hFFFF_FFFF, 32'h8000_0000, 8'd255, 12'h050));
      // register ROR by a multiple of 32, and a register amount of zero
      send_request(make_request(adp_pkg::COND_AL, adp_pkg::OP_MOV, 1'b0, 1'b1,
                                32'h0, 32'h8000_0000, 8'd64, 12'h070));
      send_request(make_request(adp_pkg::COND_AL, adp_pkg::OP_MOV, 1'b0, 1'b1,
                                32'h0, 32'h1234_5678, 8'd0, 12'h070));
      // bit 7 set in register-shift form, then the compare operations
      send_request(make_request(adp_pkg::COND_AL, adp_pkg::OP_TST, 1'b0, 1'b1,
                                32'hFFFF_FFFF, 32'hF0, 8'd4, 12'h090));
      send_request(make_request(adp_pkg::COND_AL, adp_pkg::OP_TEQ, 1'b0, 1'b1,
                                32'h5, 32'h5, 8'd0, 12'h000));
      send_request(make_request(adp_pkg::COND_AL, adp_pkg::OP_CMP, 1'b0, 1'b1,
                                32'h0, 32'h0, 8'd0, 12'h000));
      send_request(make_request(adp_pkg::COND_AL, adp_pkg::OP_CMN, 1'b0, 1'b1,
                                32'h8000_0000, 32'h8000_0000, 8'd0, 12'h000));
      // S clear leaves the flags alone; failed and never conditions do nothing
      send_request(make_request(adp_pkg::COND_AL, adp_pkg::OP_MOV, 1'b1, 1'b0,
                                32'h0, 32'h0, 8'd0, 12'h4FF));
      send_request(make_request(adp_pkg::COND_NE, adp_pkg::OP_MOV, 1'b1, 1'b1,
                                32'h0, 32'h0, 8'd0, 12'h0AB));
      send_request(make_request(adp_pkg::COND_NV, adp_pkg::OP_ADD, 1'b0, 1'b1,
                                32'h1, 32'h1, 8'd0, 12'h000));
      // register ROR, immediate ASR and LSL by 31
      send_request(make_request(adp_pkg::COND_AL, adp_pkg::OP_ADD, 1'b0, 1'b1,
                                32'h1, 32'h8000_00FF, 8'd8, 12'hFFF));
      send_request(make_request(adp_pkg::COND_AL, adp_pkg::OP_MOV, 1'b0, 1'b1,
                                32'h0, 32'h8000_0000, 8'd0, 12'hFC0));
      send_request(make_request(adp_pkg::COND_AL, adp_pkg::OP_MOV, 1'b0, 1'b1,
                                32'h0, 32'h3, 8'd0, 12'hF80));
   endtask

   task automatic test_streaming();
      set_idling(0, 0);
      run_random_requests(PHASE_ITEMS);
   endtask

   task automatic test_sparse_sender();
      set_idling(88, 0);
      run_random_requests(PHASE_ITEMS);
   endtask

   task automatic test_stalling_receiver();
      set_idling(0, 88);
      run_random_requests(PHASE_ITEMS);
   endtask

   task automatic test_both_idle();
      set_idling(6, 6);
      run_random_requests(PHASE_ITEMS);
   endtask

   // Hold the response side off for a long stretch while requests keep coming.
   task automatic test_backpressure();
      set_idling(0, 0);
      hold_token <= hold_token + 1;
      run_random_requests(50);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_streaming();
      test_sparse_sender();
      test_stalling_receiver();
      test_both_idle();
      test_backpressure();
      req_valid <= 1'b0;
      // drain outstanding responses, then let stray ones show up
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_responses.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
